@@ rtl/bsc_pkg.sv @@
// barometric sensor compensation: shared types, codes and constants
// no dependencies; imported by bsc_mul, bsc_div, the top level and the testbench
package bsc_pkg;

  typedef logic [63:0] word64_t;
  typedef logic [31:0] word32_t;

  typedef enum logic [1:0] {
    CFG_TEMP   = 2'd0,
    CFG_PRES_A = 2'd1,
    CFG_PRES_B = 2'd2,
    CFG_PRES_C = 2'd3
  } cfg_index_t;

  localparam int DIV_STAGES = 64;
  localparam int LATENCY    = 86;

  localparam word64_t T_FINE_OFFSET = 64'd128000;
  localparam word64_t P_SCALE       = 64'd3125;
  localparam word64_t P_BIAS        = 64'h0000_8000_0000_0000;
  localparam word64_t P_RAW_FULL    = 64'd1048576;
  localparam word32_t T_ROUND       = 32'd128;

  function automatic word64_t sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic word64_t asr64(word64_t x, int unsigned s);
    return word64_t'($signed(x) >>> s);
  endfunction

  function automatic word32_t asr32(word32_t x, int unsigned s);
    return word32_t'($signed(x) >>> s);
  endfunction

endpackage

@@ rtl/bsc_dly.sv @@
// barometric sensor compensation: fixed-length delay line with shared enable
// no dependencies
module bsc_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [N];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < N; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[N-1];

endmodule

@@ rtl/bsc_mul.sv @@
// barometric sensor compensation: 64x64 multiplier, low 64 bits, two stages
// depends on bsc_pkg
module bsc_mul (
  input  logic              clk,
  input  logic              en,
  input  bsc_pkg::word64_t  a,
  input  bsc_pkg::word64_t  b,
  output bsc_pkg::word64_t  p
);
  import bsc_pkg::*;

  word64_t pll;
  word32_t plh;
  word32_t phl;
  word32_t mid;

  assign mid = plh + phl;

  always_ff @(posedge clk) begin
    if (en) begin
      pll <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
      plh <= 32'(a[31:0] * b[63:32]);
      phl <= 32'(a[63:32] * b[31:0]);
      p   <= pll + {mid, 32'd0};
    end
  end

endmodule

@@ rtl/bsc_div.sv @@
// barometric sensor compensation: unsigned 64-bit restoring divider
// one quotient bit per stage; depends on bsc_pkg
module bsc_div (
  input  logic              clk,
  input  logic              en,
  input  bsc_pkg::word64_t  n,
  input  bsc_pkg::word64_t  d,
  output bsc_pkg::word64_t  q
);
  import bsc_pkg::*;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    word64_t     rem_in;
    word64_t     nq_in;
    word64_t     dv_in;
    word64_t     rem;
    word64_t     nq;
    word64_t     dv;
    word64_t     sh;
    logic [64:0] diff;
    logic        ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = n;
      assign dv_in  = d;
    end else begin : g_next
      assign rem_in = g_stage[i-1].rem;
      assign nq_in  = g_stage[i-1].nq;
      assign dv_in  = g_stage[i-1].dv;
    end

    assign sh   = {rem_in[62:0], nq_in[63]};
    assign diff = {1'b0, sh} - {1'b0, dv_in};
    assign ge   = !diff[64];

    always_ff @(posedge clk) begin
      if (en) begin
        rem <= ge ? diff[63:0] : sh;
        nq  <= {nq_in[62:0], ge};
        dv  <= dv_in;
      end
    end
  end

  assign q = g_stage[DIV_STAGES-1].nq;

endmodule

@@ rtl/barometric_sensor_compensation.sv @@
// barometric sensor compensation top level: config registers and pipeline
// depends on bsc_pkg, bsc_dly, bsc_mul, bsc_div
//
//  channel | handshake             | payload
//  in      | in_valid / in_stall   | raw_temperature, raw_pressure
//  out     | out_valid / out_stall | temperature_centi, fine_temperature,
//          |                       | pressure_q24_8, divide_by_zero
//  cfg     | cfg_wr_en             | cfg_index, cfg_data
//
// one transaction per cycle unless out_stall holds the pipeline; results leave in acceptance order
// the pipeline depth is set mostly by the 64-stage divider and the two-stage multipliers
// rst clears the calibration registers and all valid bits
// the whole pipeline holds while a result waits under out_stall
module barometric_sensor_compensation (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  bsc_pkg::cfg_index_t cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [19:0]         raw_temperature,
  input  logic [19:0]         raw_pressure,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  temperature_centi,
  output logic signed [31:0]  fine_temperature,
  output logic [31:0]         pressure_q24_8,
  output logic                divide_by_zero
);
  import bsc_pkg::*;

  logic [47:0] temp_cal;
  logic [63:0] pres_a;
  logic [63:0] pres_b;
  logic [15:0] pres_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal <= '0;
      pres_a   <= '0;
      pres_b   <= '0;
      pres_c   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TEMP:   temp_cal <= cfg_data[47:0];
        CFG_PRES_A: pres_a   <= cfg_data;
        CFG_PRES_B: pres_b   <= cfg_data;
        CFG_PRES_C: pres_c   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  word32_t t1, t2, t3;
  word64_t p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = {16'd0, temp_cal[15:0]};
  assign t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
  assign t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
  assign p1 = {48'd0, pres_a[15:0]};
  assign p2 = sx16(pres_a[31:16]);
  assign p3 = sx16(pres_a[47:32]);
  assign p4 = sx16(pres_a[63:48]);
  assign p5 = sx16(pres_b[15:0]);
  assign p6 = sx16(pres_b[31:16]);
  assign p7 = sx16(pres_b[47:32]);
  assign p8 = sx16(pres_b[63:48]);
  assign p9 = sx16(pres_c);

  logic en;
  logic [LATENCY-1:0] vld;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], in_valid};
    end
  end

  // temperature path
  logic [19:0] adc_t, adc_p;
  word32_t ta, td, dd_s, m_at, m_dd, v1, m3, fine, f5, tc, fine4;
  word64_t w1;

  assign ta   = {15'd0, adc_t[19:3]} - (t1 << 1);
  assign td   = {16'd0, adc_t[19:4]} - t1;
  assign dd_s = asr32(m_dd, 12);
  assign f5   = (fine << 2) + fine + T_ROUND;

  always_ff @(posedge clk) begin
    if (en) begin
      adc_t <= raw_temperature;
      adc_p <= raw_pressure;
      m_at  <= ta * t2;
      m_dd  <= td * td;
      v1    <= asr32(m_at, 11);
      m3    <= dd_s * t3;
      fine  <= v1 + asr32(m3, 14);
      tc    <= asr32(f5, 8);
      fine4 <= fine;
      w1    <= {{32{fine[31]}}, fine} - T_FINE_OFFSET;
    end
  end

  // pressure path
  word64_t pa, pd, pe, pb, pc, pd2, pe2, w2, sum47, sum47d, nump;
  word64_t pf, pn, den, num, mn, md, quo, pq, ps, pg, pi, ph, pi2, pq2, psum;
  logic [19:0] adc_p9;
  logic negq, negq2, dz;

  bsc_mul u_mul_a (.clk(clk), .en(en), .a(w1), .b(w1), .p(pa));
  bsc_mul u_mul_d (.clk(clk), .en(en), .a(w1), .b(p5), .p(pd));
  bsc_mul u_mul_e (.clk(clk), .en(en), .a(w1), .b(p2), .p(pe));
  bsc_mul u_mul_b (.clk(clk), .en(en), .a(pa), .b(p6), .p(pb));
  bsc_mul u_mul_c (.clk(clk), .en(en), .a(pa), .b(p3), .p(pc));

  bsc_dly #(.W(64), .N(2)) u_dly_d (.clk(clk), .en(en), .d(pd), .q(pd2));
  bsc_dly #(.W(64), .N(2)) u_dly_e (.clk(clk), .en(en), .d(pe), .q(pe2));
  bsc_dly #(.W(20), .N(9)) u_dly_p (.clk(clk), .en(en), .d(adc_p), .q(adc_p9));

  always_ff @(posedge clk) begin
    if (en) begin
      w2     <= pb + (pd2 << 17) + (p4 << 35);
      sum47  <= P_BIAS + asr64(pc, 8) + (pe2 << 12);
      nump   <= ((P_RAW_FULL - {44'd0, adc_p9}) << 31) - w2;
      sum47d <= sum47;
    end
  end

  bsc_mul u_mul_f (.clk(clk), .en(en), .a(sum47d), .b(p1), .p(pf));
  bsc_mul u_mul_n (.clk(clk), .en(en), .a(nump), .b(P_SCALE), .p(pn));

  always_ff @(posedge clk) begin
    if (en) begin
      den  <= asr64(pf, 33);
      num  <= pn;
      negq <= num[63] ^ den[63];
      dz   <= (den == '0);
      mn   <= num[63] ? -num : num;
      md   <= den[63] ? -den : den;
    end
  end

  bsc_div u_div (.clk(clk), .en(en), .n(mn), .d(md), .q(quo));
  bsc_dly #(.W(1), .N(DIV_STAGES)) u_dly_s (.clk(clk), .en(en), .d(negq), .q(negq2));

  always_ff @(posedge clk) begin
    if (en) begin
      pq <= negq2 ? -quo : quo;
    end
  end

  assign ps = asr64(pq, 13);

  bsc_mul u_mul_g (.clk(clk), .en(en), .a(ps), .b(ps), .p(pg));
  bsc_mul u_mul_i (.clk(clk), .en(en), .a(pq), .b(p8), .p(pi));
  bsc_mul u_mul_h (.clk(clk), .en(en), .a(pg), .b(p9), .p(ph));
  bsc_dly #(.W(64), .N(2)) u_dly_i (.clk(clk), .en(en), .d(pi), .q(pi2));
  bsc_dly #(.W(64), .N(4)) u_dly_q (.clk(clk), .en(en), .d(pq), .q(pq2));

  // align temperature and flag with the pressure result
  word32_t tc_a, fine_a;
  word64_t pfin;
  logic dz_a;

  bsc_dly #(.W(32), .N(80)) u_dly_tc (.clk(clk), .en(en), .d(tc), .q(tc_a));
  bsc_dly #(.W(32), .N(80)) u_dly_fn (.clk(clk), .en(en), .d(fine4), .q(fine_a));
  bsc_dly #(.W(1), .N(70)) u_dly_dz (.clk(clk), .en(en), .d(dz), .q(dz_a));

  assign pfin = asr64(psum, 8) + (p7 << 4);

  always_ff @(posedge clk) begin
    if (en) begin
      psum              <= pq2 + asr64(ph, 25) + asr64(pi2, 19);
      temperature_centi <= tc_a;
      fine_temperature  <= fine_a;
      divide_by_zero    <= dz_a;
      pressure_q24_8    <= dz_a ? 32'd0 : pfin[31:0];
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> pressure_q24_8 == 32'd0)
    else $error("pressure not cleared on zero divisor");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    en && vld[LATENCY-2] |=> out_valid)
    else $error("transaction lost in last stage");

endmodule

@@ dv/tb.sv @@
// self-checking testbench for barometric_sensor_compensation
// predicts every transaction in a scoreboard class and drives directed and random traffic
// depends on rtl/bsc_pkg.sv and rtl/barometric_sensor_compensation.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsc_pkg::*;

  typedef struct {
    logic [31:0] centi;
    logic [31:0] fine;
    logic [31:0] pres;
    logic        dz;
  } comp_result_t;

  class comp_scoreboard;
    logic [47:0] tcal;
    logic [63:0] pcal_a;
    logic [63:0] pcal_b;
    logic [15:0] pcal_c;
    comp_result_t pending[$];
    int errors;

    function new();
      tcal = 0; pcal_a = 0; pcal_b = 0; pcal_c = 0; errors = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [63:0] v);
      case (idx)
        CFG_TEMP:   tcal = v[47:0];
        CFG_PRES_A: pcal_a = v;
        CFG_PRES_B: pcal_b = v;
        CFG_PRES_C: pcal_c = v[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] sra64(logic [63:0] x, int s);
      logic signed [63:0] y;
      y = x;
      return y >>> s;
    endfunction

    function logic [31:0] sra32(logic [31:0] x, int s);
      logic signed [31:0] y;
      y = x;
      return y >>> s;
    endfunction

    function logic [63:0] sx(logic [15:0] v);
      return {{48{v[15]}}, v};
    endfunction

    function void note(logic [19:0] rt, logic [19:0] rp);
      logic [31:0] t1, t2, t3, a, d, m, v1, v2, fine;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] w1, w2, num, mn, md, q, p, ps, x1, x2;
      comp_result_t r;
      t1 = {16'd0, tcal[15:0]};
      t2 = {{16{tcal[31]}}, tcal[31:16]};
      t3 = {{16{tcal[47]}}, tcal[47:32]};
      a = {15'd0, rt[19:3]} - (t1 << 1);
      m = a * t2;
      v1 = sra32(m, 11);
      d = {16'd0, rt[19:4]} - t1;
      m = d * d;
      m = sra32(m, 12) * t3;
      v2 = sra32(m, 14);
      fine = v1 + v2;
      r.fine = fine;
      m = fine * 32'd5 + 32'd128;
      r.centi = sra32(m, 8);
      p1 = {48'd0, pcal_a[15:0]};
      p2 = sx(pcal_a[31:16]); p3 = sx(pcal_a[47:32]); p4 = sx(pcal_a[63:48]);
      p5 = sx(pcal_b[15:0]);  p6 = sx(pcal_b[31:16]); p7 = sx(pcal_b[47:32]);
      p8 = sx(pcal_b[63:48]); p9 = sx(pcal_c);
      w1 = {{32{fine[31]}}, fine} - 64'd128000;
      w2 = w1 * w1 * p6;
      w2 = w2 + ((w1 * p5) << 17);
      w2 = w2 + (p4 << 35);
      w1 = sra64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
      w1 = sra64(((64'd1 << 47) + w1) * p1, 33);
      r.pres = 0;
      r.dz = (w1 == 0);
      if (!r.dz) begin
        p = (64'd1 << 20) - {44'd0, rp};
        num = ((p << 31) - w2) * 64'd3125;
        mn = num[63] ? -num : num;
        md = w1[63] ? -w1 : w1;
        q = mn / md;
        p = (num[63] != w1[63]) ? -q : q;
        ps = sra64(p, 13);
        x1 = sra64(p9 * ps * ps, 25);
        x2 = sra64(p8 * p, 19);
        p = sra64(p + x1 + x2, 8) + (p7 << 4);
        r.pres = p[31:0];
      end
      pending.push_back(r);
    endfunction

    function void check(logic [31:0] centi, logic [31:0] fine, logic [31:0] pres, logic dz);
      comp_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected transaction on output");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (centi !== e.centi) begin
        $error("temperature_centi expected %0h actual %0h", e.centi, centi); errors++;
      end
      if (fine !== e.fine) begin
        $error("fine_temperature expected %0h actual %0h", e.fine, fine); errors++;
      end
      if (pres !== e.pres) begin
        $error("pressure_q24_8 expected %0h actual %0h", e.pres, pres); errors++;
      end
      if (dz !== e.dz) begin
        $error("divide_by_zero expected %0b actual %0b", e.dz, dz); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  cfg_index_t cfg_index = CFG_TEMP;
  logic [63:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [19:0] raw_temperature = 0;
  logic [19:0] raw_pressure = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] temperature_centi, fine_temperature;
  logic [31:0] pressure_q24_8;
  logic divide_by_zero;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  comp_scoreboard sb = new();

  barometric_sensor_compensation uut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note(raw_temperature, raw_pressure);
      if (out_valid && !out_stall)
        sb.check(temperature_centi, fine_temperature, pressure_q24_8, divide_by_zero);
    end
  end

  // receiver: random stall plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1;
    end else begin
      out_stall <= $urandom_range(99) < recv_idle;
    end
  end

  task automatic send(logic [19:0] rt, logic [19:0] rp);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1;
    raw_temperature <= rt;
    raw_pressure <= rp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [63:0] v);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic load_cal(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb, logic [15:0] pc);
    write_reg(CFG_TEMP, {16'd0, tc});
    write_reg(CFG_PRES_A, pa);
    write_reg(CFG_PRES_B, pb);
    write_reg(CFG_PRES_C, {48'd0, pc});
  endtask

  // calibration near typical parts, with random spread, or fully random
  task automatic random_cal();
    if ($urandom_range(3) == 0) begin
      load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
               16'($urandom));
    end else begin
      load_cal({16'(-1000 + $urandom_range(200)), 16'(26435 + $urandom_range(500)),
                16'(27000 + $urandom_range(1000))},
               {16'(2855 + $urandom_range(100)), 16'(3024 + $urandom_range(100)),
                16'(-10685 + $urandom_range(200)), 16'(36000 + $urandom_range(1000))},
               {16'(-14600 + $urandom_range(200)), 16'(15500 + $urandom_range(200)),
                16'(-7 + $urandom_range(14)), 16'(140 + $urandom_range(20))},
               16'(6000 + $urandom_range(200)));
    end
  endtask

  task automatic random_items(int n);
    repeat (n) begin
      case ($urandom_range(3))
        0: send(20'($urandom), 20'($urandom));
        1: send(20'($urandom_range(450000, 560000)), 20'($urandom_range(300000, 450000)));
        2: send(20'($urandom_range(0, 15)), 20'($urandom_range(1048560, 1048575)));
        default: send(20'($urandom_range(1048560, 1048575)), 20'($urandom_range(0, 15)));
      endcase
    end
  endtask

  initial begin
    #12ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // all-zero calibration: divisor is zero
    send(20'h00000, 20'h00000);
    send(20'hfffff, 20'hfffff);
    send(20'h7ef00, 20'h65a00);
    drain();
    load_cal({16'(-1000), 16'd26435, 16'd27504},
             {16'd2855, 16'd3024, 16'(-10685), 16'd36477},
             {16'(-14600), 16'd15500, 16'(-7), 16'd140}, 16'd6000);
    send(20'h7ef00, 20'h65a00);
    send(20'h00000, 20'h00000);
    send(20'hfffff, 20'hfffff);
    send(20'h00000, 20'hfffff);
    send(20'hfffff, 20'h00000);
    send(20'h80000, 20'h80000);
    drain();
    // extremes of every coefficient
    load_cal('1, '1, '1, '1);
    send(20'h00000, 20'h00000);
    send(20'hfffff, 20'hfffff);
    send(20'h55555, 20'haaaaa);
    drain();
    load_cal({16'h8000, 16'h8000, 16'hffff}, {16'h8000, 16'h8000, 16'h8000, 16'hffff},
             {4{16'h8000}}, 16'h8000);
    send(20'h00000, 20'hfffff);
    send(20'hfffff, 20'h00000);
    send(20'haaaaa, 20'h55555);
    drain();
    load_cal({16'h7fff, 16'h7fff, 16'h0000}, {16'h7fff, 16'h7fff, 16'h7fff, 16'h0001},
             {4{16'h7fff}}, 16'h7fff);
    send(20'h00000, 20'h00000);
    send(20'hfffff, 20'hfffff);
    send(20'h12345, 20'h6789a);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 34 : (ph == 1) ? 54 : 0;
      recv_idle = (ph == 0) ? 54 : (ph == 1) ? 34 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        random_cal();
        if (ph == 2 && blk == 0) hold_cycles = 400;
        random_items(120);
        drain();
      end
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/bsc_pkg.sv
rtl/bsc_dly.sv
rtl/bsc_mul.sv
rtl/bsc_div.sv
rtl/barometric_sensor_compensation.sv
dv/tb.sv
